>>> hdl/osp_pkg.sv
// osp_pkg: shared widths, payload types and the saturation helper
// for the offset surface partial derivative datapath; no dependencies
`default_nettype none

package osp_pkg;

	// number format of every vector component
	localparam int W = 32;
	localparam int F = 16;

	// derived widths
	localparam int PW = 2 * W;
	localparam int CW = PW + 1;
	localparam int SAT_IN_W = PW + 2;
	localparam int NUM_W = W + F;
	localparam int QW = NUM_W + 1;
	localparam int NW = F + 2;
	localparam int NPW = NW + W;
	localparam int SUMW = NPW + 2;
	localparam int REM_W = W + 4;

	// pipeline depths of the iterative units
	localparam int SQ_STAGES = W;
	localparam int DIV_STAGES = NUM_W;
	localparam int BACK_LAT = SQ_STAGES + 2 * DIV_STAGES + 6;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;

	typedef logic signed [W-1:0] word_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef word_t vec_t [3];

	// item handed from the front to the back
	typedef struct {
		vec_t s;
		vec_t ds;
		vec_t d;
		logic [PW-1:0] l2;
		logic degen;
	} front_t;

	// clamp a wide signed value to one word
	function automatic word_t sat_w(input logic signed [SAT_IN_W-1:0] v);
		logic [SAT_IN_W-W:0] top;
		word_t r;
		top = v[SAT_IN_W-1:W-1];
		if ((&top) || !(|top)) begin
			r = v[W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			r = {1'b1, {(W-1){1'b0}}};
		end else begin
			r = {1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/offset_surface_partial_derivative.sv
// offset_surface_partial_derivative: top level with configuration registers
// depends on osp_pkg, osp_front, osp_fifo, osp_back
//
// Usage:
//   Items enter on in_valid/in_ready with the vectors du, dv, second_a and
//   second_b as signed Q16.16 components; results leave on out_valid/out_ready
//   as res_x/y/z plus the degenerate flag, one result per item, in order.
//   Configuration writes go through cfg_valid/cfg_ready (always ready):
//   index 0 is offset_distance, index 1 is direction; other indexes are
//   dropped. Write them only while no item is in flight.
//   Throughput is one item per cycle while results are accepted. An item
//   passes through 5 front stages, the queue, a 32-stage square root, two
//   48-stage dividers (one bit per stage) and 6 multiply and sum stages.
//   When the receiver stalls, the back half holds and the 4-entry queue
//   fills; once it is full the front holds and in_ready drops.
//   Reset clears all valid flags, the queue and the configuration registers
//   (offset 0, direction u); no clearing pass is needed afterwards.
`default_nettype none

module offset_surface_partial_derivative import osp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [W-1:0]         cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [W-1:0]  du_x,
	input  logic signed [W-1:0]  du_y,
	input  logic signed [W-1:0]  du_z,
	input  logic signed [W-1:0]  dv_x,
	input  logic signed [W-1:0]  dv_y,
	input  logic signed [W-1:0]  dv_z,
	input  logic signed [W-1:0]  second_a_x,
	input  logic signed [W-1:0]  second_a_y,
	input  logic signed [W-1:0]  second_a_z,
	input  logic signed [W-1:0]  second_b_x,
	input  logic signed [W-1:0]  second_b_y,
	input  logic signed [W-1:0]  second_b_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [W-1:0]  res_x,
	output logic signed [W-1:0]  res_y,
	output logic signed [W-1:0]  res_z,
	output logic                 degenerate
);

	word_t offset_distance_q;
	logic  direction_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_distance_q <= '0;
			direction_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET:    offset_distance_q <= cfg_data;
				REG_DIRECTION: direction_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// gather the input vectors
	vec_t du, dv, va, vb;

	assign du[0] = du_x;
	assign du[1] = du_y;
	assign du[2] = du_z;
	assign dv[0] = dv_x;
	assign dv[1] = dv_y;
	assign dv[2] = dv_z;
	assign va[0] = second_a_x;
	assign va[1] = second_a_y;
	assign va[2] = second_a_z;
	assign vb[0] = second_b_x;
	assign vb[1] = second_b_y;
	assign vb[2] = second_b_z;

	logic                  push_valid, push_ready;
	front_t                push_data;
	logic                  pop_valid, pop_ready;
	front_t                pop_data;
	logic [FIFO_CNT_W-1:0] fifo_count;
	vec_t                  res;

	osp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.du         (du),
		.dv         (dv),
		.va         (va),
		.vb         (vb),
		.direction  (direction_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	osp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.count      (fifo_count)
	);

	osp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.offset_dist (offset_distance_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res),
		.degen       (degenerate)
	);

	assign res_x = res[0];
	assign res_y = res[1];
	assign res_z = res[2];

`ifndef ASSERT_OFF
	// queue level never exceeds its depth
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue level above depth");

	// the front only refuses items when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)))
		else $error("input stalled while queue has room");

	// a full queue with a held output keeps its level
	a_hold_level: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) && !pop_ready
		|=> (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)))
		else $error("queue level changed while both sides held");
`endif

endmodule

`default_nettype wire

>>> hdl/osp_isqrt.sv
// osp_isqrt: pipelined floor square root, one result bit per stage
// depends on osp_pkg for widths
`default_nettype none

module osp_isqrt import osp_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [PW-1:0] rad,
	output logic [W-1:0]  root
);

	logic [REM_W-1:0] rem_q  [SQ_STAGES];
	logic [W-1:0]     root_q [SQ_STAGES];
	logic [PW-1:0]    rad_q  [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		logic [REM_W-1:0] rem_in;
		logic [W-1:0]     root_in;
		logic [PW-1:0]    rad_in;
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_body
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign rad_in  = rad_q[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign r2    = {rem_in[REM_W-3:0], rad_in[PW-1:PW-2]};
		assign trial = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= trial) begin
					rem_q[k]  <= r2 - trial;
					root_q[k] <= {root_in[W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= r2;
					root_q[k] <= {root_in[W-2:0], 1'b0};
				end
				rad_q[k] <= {rad_in[PW-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[SQ_STAGES-1];

endmodule

`default_nettype wire

>>> hdl/osp_div.sv
// osp_div: pipelined restoring divider for (a << F) / den, truncating
// toward zero, one quotient bit per stage; depends on osp_pkg
`default_nettype none

module osp_div import osp_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  word_t                a,
	input  logic [W-1:0]         den,
	output logic signed [QW-1:0] quo
);

	logic [W:0]       rem_q [DIV_STAGES];
	logic [NUM_W-1:0] quo_q [DIV_STAGES];
	logic [NUM_W-1:0] num_q [DIV_STAGES];
	logic [W-1:0]     den_q [DIV_STAGES];
	logic             neg_q [DIV_STAGES];

	// magnitude of the shifted numerator
	logic [W-1:0]     a_mag;
	logic [NUM_W-1:0] num_in0;

	assign a_mag   = a[W-1] ? W'(-a) : W'(a);
	assign num_in0 = {a_mag, {F{1'b0}}};

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [W:0]       rem_in;
		logic [NUM_W-1:0] quo_in;
		logic [NUM_W-1:0] num_in;
		logic [W-1:0]     den_in;
		logic             neg_in;
		logic [W:0]       r2;
		logic             ge;

		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num_in0;
			assign den_in = den;
			assign neg_in = a[W-1];
		end else begin : g_body
			assign rem_in = rem_q[k-1];
			assign quo_in = quo_q[k-1];
			assign num_in = num_q[k-1];
			assign den_in = den_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		// shift in one numerator bit and subtract when it fits
		assign r2 = {rem_in[W-1:0], num_in[NUM_W-1]};
		assign ge = (r2 >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? (r2 - {1'b0, den_in}) : r2;
				quo_q[k] <= {quo_in[NUM_W-2:0], ge};
				num_q[k] <= {num_in[NUM_W-2:0], 1'b0};
				den_q[k] <= den_in;
				neg_q[k] <= neg_in;
			end
		end
	end

	// restore the sign
	logic signed [QW-1:0] quo_pos;

	assign quo_pos = $signed({1'b0, quo_q[DIV_STAGES-1]});
	assign quo     = neg_q[DIV_STAGES-1] ? -quo_pos : quo_pos;

endmodule

`default_nettype wire

>>> hdl/osp_fifo.sv
// osp_fifo: short queue between front and back halves
// depends on osp_pkg for the item type and depth
`default_nettype none

module osp_fifo import osp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  front_t                push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output front_t                pop_data,
	output logic [FIFO_CNT_W-1:0] count
);

	front_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];
	assign count      = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/osp_front.sv
// osp_front: accepts items, forms the cross products s and ds, the
// squared length and the degenerate flag; depends on osp_pkg
`default_nettype none

module osp_front import osp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  vec_t   du,
	input  vec_t   dv,
	input  vec_t   va,
	input  vec_t   vb,
	input  logic   direction,
	output logic   push_valid,
	input  logic   push_ready,
	output front_t push_data
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv;

	vec_t du_s1, dv_s1, va_s1, vb_s1, d_s1;
	prod_t sp_s2 [3];
	prod_t sn_s2 [3];
	prod_t ap_s2 [3];
	prod_t an_s2 [3];
	prod_t bp_s2 [3];
	prod_t bn_s2 [3];
	vec_t d_s2;
	vec_t s_s3, ds_s3, d_s3;
	logic [PW-1:0] sq_s4 [3];
	vec_t s_s4, ds_s4, d_s4;
	logic [PW-1:0] l2_s5;
	vec_t s_s5, ds_s5, d_s5;

	// whole front moves together unless its last stage is blocked
	assign adv      = !v_s5 || push_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// input register and selection of the base derivative
	always_ff @(posedge clk) begin
		if (adv) begin
			du_s1 <= du;
			dv_s1 <= dv;
			va_s1 <= va;
			vb_s1 <= vb;
			d_s1  <= direction ? dv : du;
			d_s2  <= d_s1;
			d_s3  <= d_s2;
			s_s4  <= s_s3;
			ds_s4 <= ds_s3;
			d_s4  <= d_s3;
			s_s5  <= s_s4;
			ds_s5 <= ds_s4;
			d_s5  <= d_s4;
			l2_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		logic signed [CW-1:0] cs;
		logic signed [CW-1:0] ca;
		logic signed [CW-1:0] cb;

		// cross product terms
		always_ff @(posedge clk) begin
			if (adv) begin
				sp_s2[i] <= du_s1[J] * dv_s1[K];
				sn_s2[i] <= du_s1[K] * dv_s1[J];
				ap_s2[i] <= va_s1[J] * dv_s1[K];
				an_s2[i] <= va_s1[K] * dv_s1[J];
				bp_s2[i] <= du_s1[J] * vb_s1[K];
				bn_s2[i] <= du_s1[K] * vb_s1[J];
			end
		end

		assign cs = CW'(sp_s2[i]) - CW'(sn_s2[i]);
		assign ca = CW'(ap_s2[i]) - CW'(an_s2[i]);
		assign cb = CW'(bp_s2[i]) - CW'(bn_s2[i]);

		// scale back to the word format, then squares for the length
		always_ff @(posedge clk) begin
			if (adv) begin
				s_s3[i]  <= sat_w(SAT_IN_W'(cs >>> F));
				ds_s3[i] <= sat_w(SAT_IN_W'(ca >>> F) + SAT_IN_W'(cb >>> F));
				sq_s4[i] <= s_s3[i] * s_s3[i];
			end
		end
	end

	assign push_valid   = v_s5;
	assign push_data.s  = s_s5;
	assign push_data.ds = ds_s5;
	assign push_data.d  = d_s5;
	assign push_data.l2 = l2_s5;
	assign push_data.degen = (l2_s5 == '0);

endmodule

`default_nettype wire

>>> hdl/osp_back.sv
// osp_back: normal length, normal derivative and the offset result
// depends on osp_pkg, osp_isqrt and osp_div
`default_nettype none

module osp_back import osp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pop_valid,
	output logic   pop_ready,
	input  front_t pop_data,
	input  word_t  offset_dist,
	output logic   out_valid,
	input  logic   out_ready,
	output vec_t   res,
	output logic   degen
);

	typedef struct {
		vec_t s;
		vec_t ds;
		vec_t d;
		logic degen;
	} side1_t;

	typedef struct {
		vec_t ds;
		vec_t d;
		logic degen;
		logic [W-1:0] len;
	} side2_t;

	typedef struct {
		vec_t d;
		logic degen;
	} side3_t;

	logic                en;
	logic [BACK_LAT-1:0] bv_q;

	// whole back moves together unless the output is held
	assign en        = !bv_q[BACK_LAT-1] || out_ready;
	assign pop_ready = en;
	assign out_valid = bv_q[BACK_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= '0;
		end else if (en) begin
			bv_q <= {bv_q[BACK_LAT-2:0], pop_valid};
		end
	end

	// square root of the squared length
	logic [W-1:0] len;

	osp_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (pop_data.l2),
		.root (len)
	);

	side1_t side1_in;
	side1_t side1_q [SQ_STAGES];

	assign side1_in.s     = pop_data.s;
	assign side1_in.ds    = pop_data.ds;
	assign side1_in.d     = pop_data.d;
	assign side1_in.degen = pop_data.degen;

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= side1_in;
			for (int k = 1; k < SQ_STAGES; k++) begin
				side1_q[k] <= side1_q[k-1];
			end
		end
	end

	// unit normal components through the first dividers
	side2_t side2_in;
	side2_t side2_q [DIV_STAGES];
	logic signed [QW-1:0] q1 [3];

	assign side2_in.ds    = side1_q[SQ_STAGES-1].ds;
	assign side2_in.d     = side1_q[SQ_STAGES-1].d;
	assign side2_in.degen = side1_q[SQ_STAGES-1].degen;
	assign side2_in.len   = len;

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[0] <= side2_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side2_q[k] <= side2_q[k-1];
			end
		end
	end

	// projection stages
	logic signed [NW-1:0]  nq [3];
	logic signed [NW-1:0]  n_s1 [3];
	logic signed [NPW-1:0] pr_s1 [3];
	vec_t                  ds_s1, d_s1;
	logic                  degen_s1;
	logic [W-1:0]          len_s1;

	word_t                 q_s2;
	logic signed [NW-1:0]  n_s2 [3];
	vec_t                  ds_s2, d_s2;
	logic                  degen_s2;
	logic [W-1:0]          len_s2;

	logic signed [NPW-1:0] qn_s3 [3];
	vec_t                  ds_s3, d_s3;
	logic                  degen_s3;
	logic [W-1:0]          len_s3;

	vec_t                  p_s4;
	vec_t                  d_s4;
	logic                  degen_s4;
	logic [W-1:0]          len_s4;

	logic signed [SUMW-1:0] dot;

	assign dot = SUMW'(pr_s1[0]) + SUMW'(pr_s1[1]) + SUMW'(pr_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s1    <= side2_q[DIV_STAGES-1].ds;
			d_s1     <= side2_q[DIV_STAGES-1].d;
			degen_s1 <= side2_q[DIV_STAGES-1].degen;
			len_s1   <= side2_q[DIV_STAGES-1].len;
			q_s2     <= sat_w(SAT_IN_W'(dot >>> F));
			n_s2     <= n_s1;
			ds_s2    <= ds_s1;
			d_s2     <= d_s1;
			degen_s2 <= degen_s1;
			len_s2   <= len_s1;
			ds_s3    <= ds_s2;
			d_s3     <= d_s2;
			degen_s3 <= degen_s2;
			len_s3   <= len_s2;
			d_s4     <= d_s3;
			degen_s4 <= degen_s3;
			len_s4   <= len_s3;
		end
	end

	// second dividers and the offset
	side3_t side3_in;
	side3_t side3_q [DIV_STAGES];
	logic signed [QW-1:0] q2 [3];
	word_t                m [3];
	prod_t                mp_s5 [3];
	vec_t                 d_s5;
	logic                 degen_s5;
	vec_t                 res_s6;
	logic                 degen_s6;

	assign side3_in.d     = d_s4;
	assign side3_in.degen = degen_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side3_q[0] <= side3_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				side3_q[k] <= side3_q[k-1];
			end
			d_s5     <= side3_q[DIV_STAGES-1].d;
			degen_s5 <= side3_q[DIV_STAGES-1].degen;
			degen_s6 <= degen_s5;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		osp_div u_div_n (
			.clk (clk),
			.en  (en),
			.a   (side1_q[SQ_STAGES-1].s[i]),
			.den (len),
			.quo (q1[i])
		);

		assign nq[i] = q1[i][NW-1:0];

		osp_div u_div_m (
			.clk (clk),
			.en  (en),
			.a   (p_s4[i]),
			.den (len_s4),
			.quo (q2[i])
		);

		assign m[i] = sat_w(SAT_IN_W'(q2[i]));

		// per-lane products, tangential part and final sum
		always_ff @(posedge clk) begin
			if (en) begin
				n_s1[i]  <= nq[i];
				pr_s1[i] <= nq[i] * side2_q[DIV_STAGES-1].ds[i];
				qn_s3[i] <= q_s2 * n_s2[i];
				p_s4[i]  <= sat_w(SAT_IN_W'(ds_s3[i]) - SAT_IN_W'(qn_s3[i] >>> F));
				mp_s5[i] <= offset_dist * m[i];
				if (degen_s5) begin
					res_s6[i] <= d_s5[i];
				end else begin
					res_s6[i] <= sat_w(SAT_IN_W'(d_s5[i]) + SAT_IN_W'(mp_s5[i] >>> F));
				end
			end
		end
	end

	assign res   = res_s6;
	assign degen = degen_s6;

endmodule

`default_nettype wire
